// ----- design/urfp_pkg.sv -----
// Package for the serial-line ring pair: command kinds, queue entry,
// result record and sequencer states. No dependencies.
package urfp_pkg;

  // Longest run of results that one get may produce
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned RUN_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PUT   = 2'd1,
    OP_GET   = 2'd2,
    OP_QUERY = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_GET_RD,
    ST_GET_EMIT
  } state_e;

  // One classified item waiting in the front queue
  typedef struct packed {
    opcode_e    kind;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       tx_ready;
    logic [7:0] put_byte;
    logic [7:0] request_len;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic       line_valid;
    logic [7:0] line_byte;
    logic       rx_dropped;
    logic       put_overflow;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       last;
    logic       space_ok;
    logic       data_waiting;
  } res_t;

endpackage

// ----- design/urfp_if.sv -----
// Valid/ready channel interfaces for the ring pair: input items and result items.
// Depends on nothing.
interface urfp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       tx_ready;
  logic [7:0] put_byte;
  logic [7:0] request_len;

  modport source (output valid, opcode, rx_valid, rx_byte, tx_ready, put_byte,
                  request_len, input ready);
  modport sink   (input valid, opcode, rx_valid, rx_byte, tx_ready, put_byte,
                  request_len, output ready);
endinterface

interface urfp_out_if;
  logic       valid;
  logic       ready;
  logic       line_valid;
  logic [7:0] line_byte;
  logic       rx_dropped;
  logic       put_overflow;
  logic       data_valid;
  logic [7:0] data_byte;
  logic       last;
  logic       space_ok;
  logic       data_waiting;

  modport source (output valid, line_valid, line_byte, rx_dropped, put_overflow,
                  data_valid, data_byte, last, space_ok, data_waiting,
                  input ready);
  modport sink   (input valid, line_valid, line_byte, rx_dropped, put_overflow,
                  data_valid, data_byte, last, space_ok, data_waiting,
                  output ready);
endinterface

// ----- design/uart_ring_fifo_pair.sv -----
// Top level of the serial-line receive/transmit ring pair.
// Depends on urfp_pkg, urfp_if, urfp_front, urfp_back (and urfp_ram below it).
//
// Two byte rings sit behind one command channel: a service tick moves one
// queued byte to the line (when tx_ready) and stores an arriving byte (or
// flags rx_dropped when the receive ring is full); a put queues one
// transmit byte (put_overflow when full); a get returns up to request_len
// received bytes, at most 32, one result per byte with last on the final
// one (a single empty result when nothing is available or request_len is
// zero); a space query reports whether free transmit room is at least
// request_len. Each ring holds at most DEPTH-1 bytes. Items enter a
// two-entry command queue and are run one at a time by a sequencer that
// works straight from the queue head. Put, query and an empty get load
// their result as soon as the sequencer takes them; a tick first reads the
// outgoing byte from a RAM with registered read and then loads its result;
// a get first sizes the run and then reads and emits each byte in turn.
// A result that is not collected stalls the sequencer; the queue still
// takes up to two more items before the input stalls. Ring storage needs
// no clearing after reset.
module uart_ring_fifo_pair
  import urfp_pkg::*;
#(
  parameter int unsigned RX_DEPTH = 32,
  parameter int unsigned TX_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  urfp_in_if.sink    in_i,
  urfp_out_if.source out_o
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Front: accept and classify items into the command queue
  urfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back: ring pointers, storage and result register
  urfp_back #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_o       (out_o)
  );

endmodule

// ----- design/urfp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module urfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/urfp_front.sv -----
// Front end: accepts input items, classifies them and holds them in a
// two-entry command queue. Depends on urfp_pkg and urfp_in_if.
module urfp_front
  import urfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  urfp_in_if.sink    in_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_pop_i
);

  cmd_t       q_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  cmd_t       cmd_in;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;

  always_comb begin
    cmd_in             = '0;
    cmd_in.kind        = opcode_e'(in_i.opcode);
    cmd_in.rx_valid    = in_i.rx_valid;
    cmd_in.rx_byte     = in_i.rx_byte;
    cmd_in.tx_ready    = in_i.tx_ready;
    cmd_in.put_byte    = in_i.put_byte;
    cmd_in.request_len = in_i.request_len;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_ptr_q];

endmodule

// ----- design/urfp_back.sv -----
// Back end: sequencer that executes queued commands against the two rings
// and drives the result register. Depends on urfp_pkg, urfp_out_if, urfp_ram.
module urfp_back
  import urfp_pkg::*;
#(
  parameter int unsigned RX_DEPTH = 32,
  parameter int unsigned TX_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  urfp_out_if.source out_o
);

  localparam int unsigned RX_PW = $clog2(RX_DEPTH);
  localparam int unsigned TX_PW = $clog2(TX_DEPTH);
  localparam int unsigned RX_CW = RX_PW + 1;
  localparam int unsigned TX_CW = TX_PW + 1;

  state_e           state_q, state_d;
  logic [RX_PW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [TX_PW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [RUN_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;

  logic             out_free, emit;
  logic [RX_PW-1:0] rx_head_nx, rx_tail_nx;
  logic [TX_PW-1:0] tx_head_nx, tx_tail_nx;
  logic [RX_CW-1:0] rx_cnt;
  logic [TX_CW-1:0] tx_cnt;
  logic [8:0]       get_n1, get_n2;
  logic [RUN_W-1:0] get_n;

  logic             rx_we, rx_re, tx_we, tx_re;
  logic [7:0]       rx_wdata, tx_wdata, rx_rdata, tx_rdata;

  urfp_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_head_q),
    .wdata_i (rx_wdata),
    .re_i    (rx_re),
    .raddr_i (rx_tail_q),
    .rdata_o (rx_rdata)
  );

  urfp_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_head_q),
    .wdata_i (tx_wdata),
    .re_i    (tx_re),
    .raddr_i (tx_tail_q),
    .rdata_o (tx_rdata)
  );

  assign out_free = !out_valid_q || out_o.ready;

  // Pointer increments with wrap at any depth
  assign rx_head_nx = (rx_head_q == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_head_q + 1'b1;
  assign rx_tail_nx = (rx_tail_q == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_tail_q + 1'b1;
  assign tx_head_nx = (tx_head_q == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_head_q + 1'b1;
  assign tx_tail_nx = (tx_tail_q == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_tail_q + 1'b1;

  assign rx_cnt = RX_CW'(rx_head_q) - RX_CW'(rx_tail_q)
                + ((rx_head_q < rx_tail_q) ? RX_CW'(RX_DEPTH) : '0);
  assign tx_cnt = TX_CW'(tx_head_q) - TX_CW'(tx_tail_q)
                + ((tx_head_q < tx_tail_q) ? TX_CW'(TX_DEPTH) : '0);

  // Run length of a get: min(request, available, MAX_RESULTS)
  assign get_n1 = (9'(cmd_i.request_len) < 9'(rx_cnt)) ? 9'(cmd_i.request_len)
                                                        : 9'(rx_cnt);
  assign get_n2 = (get_n1 < 9'(MAX_RESULTS)) ? get_n1 : 9'(MAX_RESULTS);
  assign get_n  = get_n2[RUN_W-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == OP_TICK) begin
            state_d = ST_TICK;
          end else if (cmd_i.kind == OP_GET && get_n != '0) begin
            state_d = ST_GET_RD;
          end
        end
      end
      ST_TICK: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_GET_RD: begin
        state_d = ST_GET_EMIT;
      end
      ST_GET_EMIT: begin
        if (out_free) begin
          state_d = (cnt_q == RUN_W'(1)) ? ST_IDLE : ST_GET_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs
  always_comb begin
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    cnt_d     = cnt_q;
    res_d     = '0;
    emit      = 1'b0;
    cmd_pop_o = 1'b0;
    rx_we     = 1'b0;
    rx_re     = 1'b0;
    tx_we     = 1'b0;
    tx_re     = 1'b0;
    rx_wdata  = cmd_i.rx_byte;
    tx_wdata  = cmd_i.put_byte;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            OP_TICK: begin
              tx_re = 1'b1;
            end
            OP_PUT: begin
              if (out_free) begin
                emit      = 1'b1;
                cmd_pop_o = 1'b1;
                if (tx_head_nx == tx_tail_q) begin
                  res_d.put_overflow = 1'b1;
                end else begin
                  tx_we     = 1'b1;
                  tx_head_d = tx_head_nx;
                end
                res_d.last         = 1'b1;
                res_d.data_waiting = (rx_head_q != rx_tail_q);
              end
            end
            OP_GET: begin
              if (get_n != '0) begin
                cnt_d = get_n;
              end else if (out_free) begin
                emit               = 1'b1;
                cmd_pop_o          = 1'b1;
                res_d.last         = 1'b1;
                res_d.data_waiting = (rx_head_q != rx_tail_q);
              end
            end
            OP_QUERY: begin
              if (out_free) begin
                emit               = 1'b1;
                cmd_pop_o          = 1'b1;
                res_d.space_ok     = (10'(TX_DEPTH) - 10'(tx_cnt))
                                   > 10'(cmd_i.request_len);
                res_d.last         = 1'b1;
                res_d.data_waiting = (rx_head_q != rx_tail_q);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_TICK: begin
        if (out_free) begin
          emit      = 1'b1;
          cmd_pop_o = 1'b1;
          // Transmit side first, then receive side
          if (tx_head_q != tx_tail_q && cmd_i.tx_ready) begin
            res_d.line_valid = 1'b1;
            res_d.line_byte  = tx_rdata;
            tx_tail_d        = tx_tail_nx;
          end
          if (cmd_i.rx_valid) begin
            if (rx_head_nx == rx_tail_q) begin
              res_d.rx_dropped = 1'b1;
            end else begin
              rx_we     = 1'b1;
              rx_head_d = rx_head_nx;
            end
          end
          res_d.last         = 1'b1;
          res_d.data_waiting = (rx_head_d != rx_tail_q);
        end
      end
      ST_GET_RD: begin
        rx_re = 1'b1;
      end
      ST_GET_EMIT: begin
        if (out_free) begin
          emit               = 1'b1;
          res_d.data_valid   = 1'b1;
          res_d.data_byte    = rx_rdata;
          res_d.last         = (cnt_q == RUN_W'(1));
          res_d.data_waiting = (rx_head_q != rx_tail_nx);
          rx_tail_d          = rx_tail_nx;
          cnt_d              = cnt_q - 1'b1;
          cmd_pop_o          = (cnt_q == RUN_W'(1));
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = emit || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      tx_head_q   <= '0;
      tx_tail_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rx_head_q   <= rx_head_d;
      rx_tail_q   <= rx_tail_d;
      tx_head_q   <= tx_head_d;
      tx_tail_q   <= tx_tail_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.line_valid   = res_q.line_valid;
  assign out_o.line_byte    = res_q.line_byte;
  assign out_o.rx_dropped   = res_q.rx_dropped;
  assign out_o.put_overflow = res_q.put_overflow;
  assign out_o.data_valid   = res_q.data_valid;
  assign out_o.data_byte    = res_q.data_byte;
  assign out_o.last         = res_q.last;
  assign out_o.space_ok     = res_q.space_ok;
  assign out_o.data_waiting = res_q.data_waiting;

  // A get run always has bytes left while the sequencer is in it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GET_RD || state_q == ST_GET_EMIT) |-> cnt_q != '0)
    else $error("get run active with zero count");

  // Finishing a command always returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> state_q == ST_IDLE)
    else $error("command popped but sequencer not idle");

  // Only a get run produces results that are not the last of their item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !res_d.last |-> res_d.data_valid && state_q == ST_GET_EMIT)
    else $error("non-final result outside a get run");

  // Ring head pointers stay inside their stores
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_head_q <= RX_PW'(RX_DEPTH - 1) && tx_head_q <= TX_PW'(TX_DEPTH - 1))
    else $error("ring pointer out of range");

endmodule
